// ===== rtl/core/lpi_pkg.sv =====
package lpi_pkg;

  localparam int unsigned PRE_STAGES = 7;
  localparam int unsigned DIV_STEPS  = 33;
  localparam int unsigned NUM_STAGES = PRE_STAGES + DIV_STEPS + 1;

  localparam logic [2:0] REG_PLANE_POINT_X  = 3'd0;
  localparam logic [2:0] REG_PLANE_POINT_Y  = 3'd1;
  localparam logic [2:0] REG_PLANE_POINT_Z  = 3'd2;
  localparam logic [2:0] REG_PLANE_NORMAL_X = 3'd3;
  localparam logic [2:0] REG_PLANE_NORMAL_Y = 3'd4;
  localparam logic [2:0] REG_PLANE_NORMAL_Z = 3'd5;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0]       neg;
    logic             hit;
    logic [96:0]      dsh;
    logic [2:0][96:0] rem;
    logic [2:0][32:0] q;
    logic [2:0]       ovf;
  } lpi_div_t;

endpackage

// ===== rtl/core/lpi_in_if.sv =====
interface lpi_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_point_x;
  logic [31:0] line_point_y;
  logic [31:0] line_point_z;
  logic [31:0] line_dir_x;
  logic [31:0] line_dir_y;
  logic [31:0] line_dir_z;

  modport source (output valid, line_point_x, line_point_y, line_point_z,
                  line_dir_x, line_dir_y, line_dir_z, input ready);
  modport sink (input valid, line_point_x, line_point_y, line_point_z,
                line_dir_x, line_dir_y, line_dir_z, output ready);
endinterface

// ===== rtl/core/lpi_out_if.sv =====
interface lpi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hit_x;
  logic [31:0] hit_y;
  logic [31:0] hit_z;
  logic        hits;
  logic        saturated;

  modport source (output valid, hit_x, hit_y, hit_z, hits, saturated, input ready);
  modport sink (input valid, hit_x, hit_y, hit_z, hits, saturated, output ready);
endinterface

// ===== rtl/core/lpi_div_step.sv =====
module lpi_div_step
  import lpi_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  lpi_div_t d_i,
  output lpi_div_t d_r
);

  lpi_div_t d_nxt;

  always_comb begin
    d_nxt     = d_i;
    d_nxt.dsh = d_i.dsh >> 1;
    for (int i = 0; i < 3; i++) begin
      if (d_i.rem[i] >= d_i.dsh) begin
        d_nxt.rem[i] = d_i.rem[i] - d_i.dsh;
        d_nxt.q[i]   = {d_i.q[i][31:0], 1'b1};
      end else begin
        d_nxt.q[i]   = {d_i.q[i][31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

endmodule

// ===== rtl/core/line_plane_intersection.sv =====
// Line/plane intersection in signed Q16.16. The plane (point s, normal n) is
// loaded through the cfg port while the block is idle, which the user must
// keep to; the block itself does not enforce it. Each line transfer (point p,
// direction v) yields one result p + trunc(v*n.(s-p)/n.v), clamped per
// coordinate to the 32-bit range with saturated set. A line with n.v equal to
// zero returns hits = 0 and zero coordinates. The pipeline takes one line per
// cycle unless the output stalls. It has seven stages of difference, multiply,
// sum, magnitude and scaling, then 33 restoring division steps (one quotient
// bit each, three lanes in parallel), then the add and clamp output stage.
// Stalls back up stage by stage; empty stages are filled while the output waits.
module line_plane_intersection
  import lpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  lpi_in_if.sink      in_line,
  lpi_out_if.source   out_hit
);

  logic signed [31:0] s_r [3];
  logic signed [31:0] n_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= '0;
        n_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_PLANE_POINT_X:  s_r[0] <= cfg_data;
        REG_PLANE_POINT_Y:  s_r[1] <= cfg_data;
        REG_PLANE_POINT_Z:  s_r[2] <= cfg_data;
        REG_PLANE_NORMAL_X: n_r[0] <= cfg_data;
        REG_PLANE_NORMAL_Y: n_r[1] <= cfg_data;
        REG_PLANE_NORMAL_Z: n_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES:0]   rdy;

  assign rdy[NUM_STAGES] = out_hit.ready;
  assign in_line.ready   = rdy[0];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_hs
    assign rdy[k] = !vld_r[k] || rdy[k+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        if (k == 0) vld_r[k] <= in_line.valid;
        else        vld_r[k] <= vld_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  logic signed [31:0] in_p [3];
  logic signed [31:0] in_v [3];
  assign in_p[0] = in_line.line_point_x;
  assign in_p[1] = in_line.line_point_y;
  assign in_p[2] = in_line.line_point_z;
  assign in_v[0] = in_line.line_dir_x;
  assign in_v[1] = in_line.line_dir_y;
  assign in_v[2] = in_line.line_dir_z;

  // stage 0: s - p
  logic signed [31:0] p0_r [3];
  logic signed [31:0] v0_r [3];
  logic signed [32:0] d0_r [3];
  // stage 1: products
  logic signed [31:0] p1_r [3];
  logic signed [31:0] v1_r [3];
  logic signed [64:0] nd1_r [3];
  logic signed [63:0] nv1_r [3];
  // stage 2: dot products
  logic signed [31:0] p2_r [3];
  logic signed [31:0] v2_r [3];
  logic signed [66:0] num2_r;
  logic signed [65:0] den2_r;
  // stage 3: magnitudes
  logic [2:0][31:0]   p3_r;
  logic [2:0]         neg3_r;
  logic [31:0]        vm3_r [3];
  logic [65:0]        nm3_r;
  logic [63:0]        dm3_r;
  logic               hit3_r;
  // stage 4: partial products
  logic [2:0][31:0]   p4_r;
  logic [2:0]         neg4_r;
  logic [64:0]        pl4_r [3];
  logic [64:0]        ph4_r [3];
  logic [63:0]        dm4_r;
  logic               hit4_r;
  // stage 5: full product
  logic [2:0][31:0]   p5_r;
  logic [2:0]         neg5_r;
  logic [96:0]        pr5_r [3];
  logic [63:0]        dm5_r;
  logic               hit5_r;
  // stage 6 onward: division
  lpi_div_t           dv_r [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int i = 0; i < 3; i++) begin
        p0_r[i] <= in_p[i];
        v0_r[i] <= in_v[i];
        d0_r[i] <= 33'(s_r[i]) - 33'(in_p[i]);
      end
    end
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i]  <= p0_r[i];
        v1_r[i]  <= v0_r[i];
        nd1_r[i] <= 65'(n_r[i]) * 65'(d0_r[i]);
        nv1_r[i] <= 64'(n_r[i]) * 64'(v0_r[i]);
      end
    end
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        p2_r[i] <= p1_r[i];
        v2_r[i] <= v1_r[i];
      end
      num2_r <= 67'(nd1_r[0]) + 67'(nd1_r[1]) + 67'(nd1_r[2]);
      den2_r <= 66'(nv1_r[0]) + 66'(nv1_r[1]) + 66'(nv1_r[2]);
    end
    if (rdy[3]) begin
      for (int i = 0; i < 3; i++) begin
        p3_r[i]   <= p2_r[i];
        neg3_r[i] <= num2_r[66] ^ den2_r[65] ^ v2_r[i][31];
        vm3_r[i]  <= v2_r[i][31] ? 32'(-v2_r[i]) : 32'(v2_r[i]);
      end
      nm3_r  <= num2_r[66] ? 66'(-num2_r) : 66'(num2_r);
      dm3_r  <= den2_r[65] ? 64'(-den2_r) : 64'(den2_r);
      hit3_r <= (den2_r != '0);
    end
    if (rdy[4]) begin
      p4_r   <= p3_r;
      neg4_r <= neg3_r;
      for (int i = 0; i < 3; i++) begin
        pl4_r[i] <= 65'(nm3_r[32:0]) * 65'(vm3_r[i]);
        ph4_r[i] <= 65'(nm3_r[65:33]) * 65'(vm3_r[i]);
      end
      dm4_r  <= dm3_r;
      hit4_r <= hit3_r;
    end
    if (rdy[5]) begin
      p5_r   <= p4_r;
      neg5_r <= neg4_r;
      for (int i = 0; i < 3; i++) begin
        pr5_r[i] <= 97'({ph4_r[i], 33'b0}) + 97'(pl4_r[i]);
      end
      dm5_r  <= dm4_r;
      hit5_r <= hit4_r;
    end
    if (rdy[6]) begin
      dv_r[0].p   <= p5_r;
      dv_r[0].neg <= neg5_r;
      dv_r[0].hit <= hit5_r;
      dv_r[0].dsh <= 97'({dm5_r, 32'b0});
      for (int i = 0; i < 3; i++) begin
        dv_r[0].rem[i] <= pr5_r[i];
        dv_r[0].q[i]   <= '0;
        dv_r[0].ovf[i] <= (pr5_r[i] >= {dm5_r, 33'b0});
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    lpi_div_step u_step (
      .clk (clk),
      .en  (rdy[PRE_STAGES+j]),
      .d_i (dv_r[j]),
      .d_r (dv_r[j+1])
    );
  end

  // output stage: p +/- q with clamp
  lpi_div_t           fin;
  logic signed [34:0] pe, qe, rs;
  logic [31:0]        res_nxt [3];
  logic [2:0]         sat_c;
  logic [31:0]        res_r [3];
  logic               hits_r;
  logic               sat_r;

  assign fin = dv_r[DIV_STEPS];

  always_comb begin
    pe = '0;
    qe = '0;
    rs = '0;
    for (int i = 0; i < 3; i++) begin
      pe = {{3{fin.p[i][31]}}, fin.p[i]};
      qe = {2'b0, fin.q[i]};
      rs = fin.neg[i] ? pe - qe : pe + qe;
      sat_c[i] = 1'b0;
      if (!fin.hit) begin
        res_nxt[i] = '0;
      end else if (fin.ovf[i]) begin
        res_nxt[i] = fin.neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
        sat_c[i]   = 1'b1;
      end else if (rs > 35'sh0_7fff_ffff) begin
        res_nxt[i] = 32'h7fff_ffff;
        sat_c[i]   = 1'b1;
      end else if (rs < -35'sh0_8000_0000) begin
        res_nxt[i] = 32'h8000_0000;
        sat_c[i]   = 1'b1;
      end else begin
        res_nxt[i] = rs[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NUM_STAGES-1]) begin
      for (int i = 0; i < 3; i++) res_r[i] <= res_nxt[i];
      hits_r <= fin.hit;
      sat_r  <= |sat_c;
    end
  end

  assign out_hit.valid     = vld_r[NUM_STAGES-1];
  assign out_hit.hit_x     = res_r[0];
  assign out_hit.hit_y     = res_r[1];
  assign out_hit.hit_z     = res_r[2];
  assign out_hit.hits      = hits_r;
  assign out_hit.saturated = sat_r;

endmodule
